@@ rtl/core/ctkd_pkg.sv @@
// Shared types and constants of the capacitive touch key detector.
`default_nettype none

package ctkd_pkg;

   // Field widths fixed by the beat formats.
   localparam int SAMPLE_W   = 16;
   localparam int GATE_W     = 16;
   localparam int HOLD_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic [GATE_W-1:0] GATE_RESET = 16'd100;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 4'd3;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF_RELOAD = 1'b1;

   // Item and result kinds.
   localparam logic KIND_CAL  = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   typedef struct packed {
      logic                req_type;
      logic [SAMPLE_W-1:0] sample;
      logic                last_of_group;
      logic                clear_holdoff;
   } ctkd_req_beat_type;

   typedef struct packed {
      logic                result_kind;
      logic                touched;
      logic [SAMPLE_W-1:0] baseline_out;
      logic [SAMPLE_W-1:0] peak_out;
      logic                cal_fail;
   } ctkd_rsp_beat_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } ctkd_alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIVOT_RD,
      ST_PIVOT,
      ST_RANK,
      ST_ACCUM,
      ST_DIVIDE,
      ST_CAL_END,
      ST_PEAK,
      ST_THR_ADD,
      ST_THR_CMP,
      ST_EMIT
   } ctkd_state_type;

endpackage

`default_nettype wire

@@ rtl/core/capacitive_touch_key_detector.sv @@
// Top level of the capacitive touch key detector: sequencer, state and shared unit.
//
//   Port group | Direction | Beat contents
//   -----------+-----------+----------------------------------------------------
//   req_*      | in        | req_type, sample, last_of_group, clear_holdoff
//   rsp_*      | out       | result_kind, touched, baseline_out, peak_out, cal_fail
//   csr_*      | in        | write enable, register index, write data
//
// A calibration beat is written into the sample RAM; the one that finishes a round
// then runs a rank pass over that RAM on the one shared adder, ranking each sample
// against every sample and summing those kept. The trimmed mean follows as a multiply
// by the reciprocal of the kept count. A scan beat updates the group peak; one that
// closes a group adds the gate to the baseline, compares the peak and emits a result.
// Reset is synchronous; it sets gate and reload to their reset values and clears the
// rest of the control state. The sample RAM is not cleared, as a round only reads
// entries written in the same round. A stalled result sits in the output register.
// A finished result waits in the emit state only while that register is still occupied.
`default_nettype none

module capacitive_touch_key_detector #(
   parameter int CAL_SAMPLES    = 10,
   parameter int TRIM_EACH_SIDE = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ctkd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctkd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ctkd_pkg::ctkd_req_beat_type          req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ctkd_pkg::ctkd_rsp_beat_type          rsp_data
);

   import ctkd_pkg::*;

   // Sample RAM addressing and the width of the running sum, which never wraps.
   localparam int AW    = $clog2(CAL_SAMPLES);
   localparam int SUM_W = SAMPLE_W + $clog2(CAL_SAMPLES + 1);
   // Number of samples kept after trimming. When trimming removes every sample no
   // rank falls inside the window, the sum stays zero and dividing by one gives a
   // zero baseline.
   localparam int KEEP  = (CAL_SAMPLES > 2 * TRIM_EACH_SIDE) ?
                          (CAL_SAMPLES - 2 * TRIM_EACH_SIDE) : 1;

   // The mean is the sum times a rounded-up reciprocal of KEEP, shifted down. With
   // this shift the quotient is exact for every sum that fits in SUM_W bits.
   localparam int     DIV_SHIFT = SUM_W + $clog2(KEEP);
   localparam int     REC_W     = SUM_W + 1;
   localparam int     PROD_W    = SUM_W + REC_W;
   localparam longint RECIP_VAL = ((longint'(1) << DIV_SHIFT) + longint'(KEEP) -
                                   longint'(1)) / longint'(KEEP);

   localparam logic [AW-1:0]    LAST_IDX = AW'(CAL_SAMPLES - 1);
   localparam logic [REC_W-1:0] RECIP    = REC_W'(RECIP_VAL);

   // Control state.
   ctkd_state_type      state_ff, state_in;
   logic [AW-1:0]       cal_count_ff, cal_count_in;
   logic [SAMPLE_W-1:0] baseline_ff, baseline_in;
   logic [SAMPLE_W-1:0] group_peak_ff, group_peak_in;
   logic [HOLD_W-1:0]   holdoff_ff, holdoff_in;
   logic [GATE_W-1:0]   gate_ff, gate_in;
   logic [HOLD_W-1:0]   reload_ff, reload_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers of the sequencer.
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                last_ff, last_in;
   logic                clr_ff, clr_in;
   logic [SAMPLE_W-1:0] pivot_ff, pivot_in;
   logic [AW-1:0]       idx_i_ff, idx_i_in;
   logic [AW-1:0]       idx_j_ff, idx_j_in;
   logic [AW-1:0]       rank_ff, rank_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   ctkd_rsp_beat_type   res_ff, res_in;
   ctkd_rsp_beat_type   rsp_ff, rsp_in;

   // Shared unit and RAM connections.
   ctkd_alu_op_type     alu_op;
   logic [SUM_W-1:0]    alu_a, alu_b;
   logic [SUM_W:0]      alu_res;
   logic                ram_we;
   logic [AW-1:0]       ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   // Helper terms.
   logic                accept;
   logic                slot_free;
   logic [PROD_W-1:0]   quot_prod;
   logic                in_window;
   logic                over;
   logic [HOLD_W-1:0]   hold_next;
   logic [SAMPLE_W-1:0] new_peak;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sum of the kept samples times the reciprocal of their count.
   assign quot_prod = {REC_W'(0), sum_ff} * {SUM_W'(0), RECIP};
   assign in_window = (int'(rank_ff) >= TRIM_EACH_SIDE) &&
                      (int'(rank_ff) < CAL_SAMPLES - TRIM_EACH_SIDE);
   // In the threshold compare sum_ff holds baseline plus gate; a borrow means the
   // peak lies above it.
   assign over      = alu_res[SUM_W];
   assign hold_next = over ? reload_ff : holdoff_ff;
   assign new_peak  = alu_res[SUM_W] ? sample_ff : group_peak_ff;

   ctkd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CAL_SAMPLES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cal_count_ff),
      .wr_data (req_data.sample),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ctkd_alu #(
      .WIDTH (SUM_W)
   ) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == KIND_SCAN) begin
                  state_in = ST_PEAK;
               end else if (cal_count_ff == LAST_IDX) begin
                  state_in = ST_PIVOT_RD;
               end
            end
         end
         ST_PIVOT_RD: state_in = ST_PIVOT;
         ST_PIVOT:    state_in = ST_RANK;
         ST_RANK: begin
            if (idx_j_ff == LAST_IDX) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = (idx_i_ff == LAST_IDX) ? ST_DIVIDE : ST_PIVOT_RD;
         end
         ST_DIVIDE:   state_in = ST_CAL_END;
         ST_CAL_END:  state_in = ST_EMIT;
         ST_PEAK:     state_in = last_ff ? ST_THR_ADD : ST_IDLE;
         ST_THR_ADD:  state_in = ST_THR_CMP;
         ST_THR_CMP:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      cal_count_in  = cal_count_ff;
      baseline_in   = baseline_ff;
      group_peak_in = group_peak_ff;
      holdoff_in    = holdoff_ff;
      gate_in       = gate_ff;
      reload_in     = reload_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      sample_in     = sample_ff;
      last_in       = last_ff;
      clr_in        = clr_ff;
      pivot_in      = pivot_ff;
      idx_i_in      = idx_i_ff;
      idx_j_in      = idx_j_ff;
      rank_in       = rank_ff;
      sum_in        = sum_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      alu_op        = ALU_SUB;
      alu_a         = sum_ff;
      alu_b         = SUM_W'(pivot_ff);
      ram_we        = 1'b0;
      ram_rd_addr   = idx_i_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_GATE_THRESHOLD: gate_in   = csr_wdata[GATE_W-1:0];
            CSR_HOLDOFF_RELOAD: reload_in = csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == KIND_SCAN) begin
                  sample_in = req_data.sample;
                  last_in   = req_data.last_of_group;
                  clr_in    = req_data.clear_holdoff;
               end else begin
                  ram_we = 1'b1;
                  if (cal_count_ff == LAST_IDX) begin
                     cal_count_in = '0;
                     idx_i_in     = '0;
                     sum_in       = '0;
                  end else begin
                     cal_count_in = cal_count_ff + 1'b1;
                  end
               end
            end
         end
         ST_PIVOT_RD: begin
            ram_rd_addr = idx_i_ff;
         end
         ST_PIVOT: begin
            pivot_in    = ram_rd_data;
            ram_rd_addr = '0;
            idx_j_in    = '0;
            rank_in     = '0;
         end
         ST_RANK: begin
            // Ties are broken by position so that every sample gets a distinct rank.
            alu_op = ALU_SUB;
            alu_a  = SUM_W'(ram_rd_data);
            alu_b  = SUM_W'(pivot_ff);
            if (alu_res[SUM_W] ||
                ((alu_res[SUM_W-1:0] == '0) && (idx_j_ff < idx_i_ff))) begin
               rank_in = rank_ff + 1'b1;
            end
            if (idx_j_ff == LAST_IDX) begin
               ram_rd_addr = '0;
            end else begin
               ram_rd_addr = idx_j_ff + 1'b1;
               idx_j_in    = idx_j_ff + 1'b1;
            end
         end
         ST_ACCUM: begin
            alu_op = ALU_ADD;
            alu_a  = sum_ff;
            alu_b  = SUM_W'(pivot_ff);
            if (in_window) begin
               sum_in = alu_res[SUM_W-1:0];
            end
            if (idx_i_ff != LAST_IDX) begin
               idx_i_in = idx_i_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            sum_in = SUM_W'(quot_prod >> DIV_SHIFT);
         end
         ST_CAL_END: begin
            baseline_in         = sum_ff[SAMPLE_W-1:0];
            res_in.result_kind  = KIND_CAL;
            res_in.touched      = 1'b0;
            res_in.baseline_out = sum_ff[SAMPLE_W-1:0];
            res_in.peak_out     = '0;
            res_in.cal_fail     = sum_ff[SAMPLE_W-1];
         end
         ST_PEAK: begin
            alu_op = ALU_SUB;
            alu_a  = SUM_W'(group_peak_ff);
            alu_b  = SUM_W'(sample_ff);
            if (last_ff) begin
               pivot_in      = new_peak;
               group_peak_in = '0;
               if (clr_ff) begin
                  holdoff_in = '0;
               end
            end else begin
               group_peak_in = new_peak;
            end
         end
         ST_THR_ADD: begin
            alu_op = ALU_ADD;
            alu_a  = SUM_W'(baseline_ff);
            alu_b  = SUM_W'(gate_ff);
            sum_in = alu_res[SUM_W-1:0];
         end
         ST_THR_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = sum_ff;
            alu_b  = SUM_W'(pivot_ff);
            holdoff_in = (hold_next != '0) ? hold_next - 1'b1 : hold_next;
            res_in.result_kind  = KIND_SCAN;
            res_in.touched      = over && (holdoff_ff == '0);
            res_in.baseline_out = baseline_ff;
            res_in.peak_out     = pivot_ff;
            res_in.cal_fail     = 1'b0;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cal_count_ff  <= '0;
         baseline_ff   <= '0;
         group_peak_ff <= '0;
         holdoff_ff    <= '0;
         gate_ff       <= GATE_RESET;
         reload_ff     <= HOLD_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cal_count_ff  <= cal_count_in;
         baseline_ff   <= baseline_in;
         group_peak_ff <= group_peak_in;
         holdoff_ff    <= holdoff_in;
         gate_ff       <= gate_in;
         reload_ff     <= reload_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      last_ff    <= last_in;
      clr_ff     <= clr_in;
      pivot_ff   <= pivot_in;
      idx_i_ff   <= idx_i_in;
      idx_j_ff   <= idx_j_in;
      rank_ff    <= rank_in;
      sum_ff     <= sum_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/ctkd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ctkd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/ctkd_alu.sv @@
// Shared add/subtract unit; the top bit of the result is the carry or borrow.
`default_nettype none

module ctkd_alu #(
   parameter int WIDTH = 20
) (
   input  ctkd_pkg::ctkd_alu_op_type op,
   input  logic [WIDTH-1:0]          a,
   input  logic [WIDTH-1:0]          b,
   output logic [WIDTH:0]            res
);

   import ctkd_pkg::*;

   always_comb begin
      unique case (op)
         ALU_ADD: res = {1'b0, a} + {1'b0, b};
         ALU_SUB: res = {1'b0, a} - {1'b0, b};
         default: res = '0;
      endcase
   end

endmodule

`default_nettype wire
